// ===== src/pdsf_pkg.sv =====
// package: shared constants, types and codes of the periodic dip scale factor
`default_nettype none
package pdsf_pkg;

    // default parameter values
    localparam int ANGLE_WIDTH_DEF   = 16;
    localparam int MAX_SHARPNESS_DEF = 15;

    // q15 constants and sine polynomial coefficients
    localparam logic [15:0] Q15_ONE = 16'd32768;
    localparam logic [15:0] Q15_QTR = 16'd16384;
    localparam logic [15:0] SIN_A   = 16'd51472;
    localparam logic [15:0] SIN_B   = 16'd21167;
    localparam logic [15:0] SIN_C   = 16'd2463;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEPTH  = 2'd0,
        CFG_SHARP  = 2'd1,
        CFG_PERIOD = 2'd2,
        CFG_PHASE  = 2'd3
    } cfg_idx_t;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_MOD,
        S_MODFIX,
        S_FRAC,
        S_FOLD,
        S_Z2,
        S_C,
        S_U,
        S_S,
        S_Q,
        S_P,
        S_M
    } state_t;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MOD_STEP,
        OP_MOD_FIX,
        OP_FRAC_STEP,
        OP_FOLD,
        OP_Z2,
        OP_C,
        OP_U,
        OP_S,
        OP_Q,
        OP_P,
        OP_M
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic out_full;
    } dp_stat_t;

endpackage
`default_nettype wire

// ===== src/pdsf_if.sv =====
// interfaces: angle input channel and scale output channel
`default_nettype none
interface pdsf_angle_if #(
    parameter int ANGLE_WIDTH = pdsf_pkg::ANGLE_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [ANGLE_WIDTH-1:0] angle;

    modport source (output valid, output angle, input ready);
    modport sink   (input valid, input angle, output ready);
endinterface

interface pdsf_scale_if;
    logic        valid;
    logic        ready;
    logic [15:0] scale;

    modport source (output valid, output scale, input ready);
    modport sink   (input valid, input scale, output ready);
endinterface
`default_nettype wire

// ===== src/pdsf_ctrl.sv =====
// controller: sequences the modulo, fraction divide and multiply steps
`default_nettype none
module pdsf_ctrl #(
    parameter int ANGLE_WIDTH   = pdsf_pkg::ANGLE_WIDTH_DEF,
    parameter int MAX_SHARPNESS = pdsf_pkg::MAX_SHARPNESS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [3:0]        sharp,
    input  wire pdsf_pkg::dp_stat_t stat,
    output pdsf_pkg::dp_cmd_t      cmd
);
    localparam int DW   = ((ANGLE_WIDTH > 16) ? ANGLE_WIDTH : 16) + 1;
    localparam int MAXC = (DW > MAX_SHARPNESS) ? DW : MAX_SHARPNESS;
    localparam int CW   = $clog2(MAXC + 1);

    pdsf_pkg::state_t state_reg, state_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [CW-1:0]    n_sat;

    // saturate the exponent count
    assign n_sat = (CW'(sharp) > CW'(MAX_SHARPNESS)) ? CW'(MAX_SHARPNESS) : CW'(sharp);

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pdsf_pkg::S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd.op     = pdsf_pkg::OP_NONE;
        in_ready   = 1'b0;
        unique case (state_reg)
            pdsf_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = pdsf_pkg::OP_LOAD;
                    cnt_next   = CW'(DW - 1);
                    state_next = pdsf_pkg::S_MOD;
                end
            end
            pdsf_pkg::S_MOD:
            begin
                cmd.op   = pdsf_pkg::OP_MOD_STEP;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = pdsf_pkg::S_MODFIX;
                end
            end
            pdsf_pkg::S_MODFIX:
            begin
                cmd.op     = pdsf_pkg::OP_MOD_FIX;
                cnt_next   = CW'(15);
                state_next = pdsf_pkg::S_FRAC;
            end
            pdsf_pkg::S_FRAC:
            begin
                cmd.op   = pdsf_pkg::OP_FRAC_STEP;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = pdsf_pkg::S_FOLD;
                end
            end
            pdsf_pkg::S_FOLD:
            begin
                cmd.op     = pdsf_pkg::OP_FOLD;
                state_next = pdsf_pkg::S_Z2;
            end
            pdsf_pkg::S_Z2:
            begin
                cmd.op     = pdsf_pkg::OP_Z2;
                state_next = pdsf_pkg::S_C;
            end
            pdsf_pkg::S_C:
            begin
                cmd.op     = pdsf_pkg::OP_C;
                state_next = pdsf_pkg::S_U;
            end
            pdsf_pkg::S_U:
            begin
                cmd.op     = pdsf_pkg::OP_U;
                state_next = pdsf_pkg::S_S;
            end
            pdsf_pkg::S_S:
            begin
                cmd.op     = pdsf_pkg::OP_S;
                state_next = pdsf_pkg::S_Q;
            end
            pdsf_pkg::S_Q:
            begin
                cmd.op     = pdsf_pkg::OP_Q;
                cnt_next   = n_sat;
                state_next = pdsf_pkg::S_P;
            end
            pdsf_pkg::S_P:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = pdsf_pkg::S_M;
                end
                else
                begin
                    cmd.op   = pdsf_pkg::OP_P;
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            pdsf_pkg::S_M:
            begin
                // wait for a free output slot
                if (!stat.out_full)
                begin
                    cmd.op     = pdsf_pkg::OP_M;
                    state_next = pdsf_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pdsf_pkg::S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

// ===== src/pdsf_dp.sv =====
// datapath: modulo and fraction dividers, shared q15 multiplier, output register
`default_nettype none
module pdsf_dp #(
    parameter int ANGLE_WIDTH = pdsf_pkg::ANGLE_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire pdsf_pkg::dp_cmd_t             cmd,
    output pdsf_pkg::dp_stat_t                 stat,
    input  wire logic signed [ANGLE_WIDTH-1:0] angle,
    input  wire logic [15:0]                   depth,
    input  wire logic [14:0]                   period,
    input  wire logic signed [15:0]            phase,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [15:0]                        out_scale
);
    localparam int DW = ((ANGLE_WIDTH > 16) ? ANGLE_WIDTH : 16) + 1;

    logic [DW-1:0] mag_reg;
    logic          neg_reg;
    logic [15:0]   rem_reg;
    logic [15:0]   f_reg;
    logic [15:0]   z_reg, z2_reg, w_reg, p_reg, q_reg;
    logic [15:0]   scale_reg;
    logic          ovalid_reg;

    logic signed [DW-1:0] d_val;
    logic [14:0]          per;
    logic [15:0]          per16;
    logic [15:0]          cand_mod, cand_frac;
    logic [15:0]          h_val, h_fold;
    logic [15:0]          mul_a, mul_b;
    logic [31:0]          mprod;
    logic [32:0]          prod;
    logic [17:0]          qm;
    logic [15:0]          depth_sat;
    logic [15:0]          s_clamp;

    // difference, period guard, depth saturation
    assign d_val     = DW'(angle) - DW'(phase);
    assign per       = (period == '0) ? 15'd1 : period;
    assign per16     = {1'b0, per};
    assign depth_sat = (depth > pdsf_pkg::Q15_ONE) ? pdsf_pkg::Q15_ONE : depth;

    // restoring divider candidates
    assign cand_mod  = {rem_reg[14:0], mag_reg[DW-1]};
    assign cand_frac = {rem_reg[14:0], 1'b0};

    // fold the turn fraction into a quarter wave
    assign h_val  = {1'b0, f_reg[14:0]};
    assign h_fold = (h_val > pdsf_pkg::Q15_QTR) ? (pdsf_pkg::Q15_ONE - h_val) : h_val;

    // shared multiplier operand select
    always_comb
    begin
        mul_a = z_reg;
        mul_b = z_reg;
        unique case (cmd.op)
            pdsf_pkg::OP_C:
            begin
                mul_a = z2_reg;
                mul_b = pdsf_pkg::SIN_C;
            end
            pdsf_pkg::OP_U:
            begin
                mul_a = z2_reg;
                mul_b = w_reg;
            end
            pdsf_pkg::OP_S:
            begin
                mul_a = z_reg;
                mul_b = w_reg;
            end
            pdsf_pkg::OP_Q:
            begin
                mul_a = w_reg;
                mul_b = w_reg;
            end
            pdsf_pkg::OP_P:
            begin
                mul_a = p_reg;
                mul_b = q_reg;
            end
            pdsf_pkg::OP_M:
            begin
                mul_a = depth_sat;
                mul_b = p_reg;
            end
            default:
            begin
                mul_a = z_reg;
                mul_b = z_reg;
            end
        endcase
    end

    // rounded q15 product
    assign mprod   = {16'd0, mul_a} * {16'd0, mul_b};
    assign prod    = {1'b0, mprod} + 33'd16384;
    assign qm      = prod[32:15];
    assign s_clamp = (qm > 18'(pdsf_pkg::Q15_ONE)) ? pdsf_pkg::Q15_ONE : qm[15:0];

    // working registers
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            pdsf_pkg::OP_LOAD:
            begin
                neg_reg <= d_val[DW-1];
                mag_reg <= d_val[DW-1] ? DW'(-d_val) : DW'(d_val);
                rem_reg <= '0;
            end
            pdsf_pkg::OP_MOD_STEP:
            begin
                mag_reg <= {mag_reg[DW-2:0], 1'b0};
                rem_reg <= (cand_mod >= per16) ? (cand_mod - per16) : cand_mod;
            end
            pdsf_pkg::OP_MOD_FIX:
            begin
                if (neg_reg && (rem_reg != '0))
                begin
                    rem_reg <= per16 - rem_reg;
                end
            end
            pdsf_pkg::OP_FRAC_STEP:
            begin
                rem_reg <= (cand_frac >= per16) ? (cand_frac - per16) : cand_frac;
                f_reg   <= {f_reg[14:0], (cand_frac >= per16)};
            end
            pdsf_pkg::OP_FOLD:
            begin
                z_reg <= {h_fold[14:0], 1'b0};
            end
            pdsf_pkg::OP_Z2:
            begin
                z2_reg <= qm[15:0];
            end
            pdsf_pkg::OP_C:
            begin
                w_reg <= pdsf_pkg::SIN_B - qm[15:0];
            end
            pdsf_pkg::OP_U:
            begin
                w_reg <= pdsf_pkg::SIN_A - qm[15:0];
            end
            pdsf_pkg::OP_S:
            begin
                w_reg <= s_clamp;
            end
            pdsf_pkg::OP_Q:
            begin
                q_reg <= qm[15:0];
                p_reg <= pdsf_pkg::Q15_ONE;
            end
            pdsf_pkg::OP_P:
            begin
                p_reg <= qm[15:0];
            end
            pdsf_pkg::OP_M:
            begin
                scale_reg <= (qm >= 18'(pdsf_pkg::Q15_ONE)) ? 16'd0
                                                           : (pdsf_pkg::Q15_ONE - qm[15:0]);
            end
            default:
            begin
            end
        endcase
    end

    // output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else if (cmd.op == pdsf_pkg::OP_M)
        begin
            ovalid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            ovalid_reg <= 1'b0;
        end
    end

    assign out_valid     = ovalid_reg;
    assign out_scale     = scale_reg;
    assign stat.out_full = ovalid_reg && !out_ready;
endmodule
`default_nettype wire

// ===== src/periodic_dip_scale_factor.sv =====
// top level: configuration registers, controller and datapath of the dip scale factor
//
// Usage: one angle item in on in_ch, one scale item out on out_ch, both
// valid/ready channels. Configuration is written through cfg_we, cfg_index
// and cfg_wdata (0 depth, 1 sharpness, 2 period, 3 phase); the user must
// write it only while idle, since the block itself does not enforce this.
// Sequence: after an item is accepted the block runs a bit-serial modulo
// by the period, a sign fix, a bit-serial fraction divide, a quarter-wave
// fold, five products on the shared 16x16 multiplier for the sine and its
// square, one product per sharpness step plus an exit step, and the final
// depth product.
// Items are processed one at a time; in_ch.ready is high only when idle.
// The next item is accepted while a finished result still waits.
// Reset clears the controller and the output valid flag and loads the
// registers with depth 0, sharpness 1, period 6434 and phase 0.
// When the receiver stalls the result is held and the final step of the
// next item waits until the output register frees up.
`default_nettype none
module periodic_dip_scale_factor #(
    parameter int ANGLE_WIDTH   = pdsf_pkg::ANGLE_WIDTH_DEF,
    parameter int MAX_SHARPNESS = pdsf_pkg::MAX_SHARPNESS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [pdsf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [pdsf_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    pdsf_angle_if.sink                             in_ch,
    pdsf_scale_if.source                           out_ch
);
    logic [15:0]        depth_reg;
    logic [3:0]         sharp_reg;
    logic [14:0]        period_reg;
    logic signed [15:0] phase_reg;

    pdsf_pkg::dp_cmd_t  cmd;
    pdsf_pkg::dp_stat_t stat;
    logic               in_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg  <= 16'd0;
            sharp_reg  <= 4'd1;
            period_reg <= 15'd6434;
            phase_reg  <= 16'sd0;
        end
        else if (cfg_we)
        begin
            unique case (pdsf_pkg::cfg_idx_t'(cfg_index))
                pdsf_pkg::CFG_DEPTH:  depth_reg  <= cfg_wdata;
                pdsf_pkg::CFG_SHARP:  sharp_reg  <= cfg_wdata[3:0];
                pdsf_pkg::CFG_PERIOD: period_reg <= cfg_wdata[14:0];
                pdsf_pkg::CFG_PHASE:  phase_reg  <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    assign in_ch.ready = in_ready;

    // sequencer
    pdsf_ctrl #(
        .ANGLE_WIDTH   (ANGLE_WIDTH),
        .MAX_SHARPNESS (MAX_SHARPNESS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .sharp    (sharp_reg),
        .stat     (stat),
        .cmd      (cmd)
    );

    // arithmetic
    pdsf_dp #(
        .ANGLE_WIDTH (ANGLE_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .angle     (in_ch.angle),
        .depth     (depth_reg),
        .period    (period_reg),
        .phase     (phase_reg),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_scale (out_ch.scale)
    );
endmodule
`default_nettype wire
